>>> hdl/r24c_pkg.sv
// Package for the 24-dot column bit-image encoder.
// Holds the queue item type, command byte constants and the column transpose.
// Used by every design module of the block; depends on nothing.
`default_nettype none

package r24c_pkg;

    localparam int BAND_ROWS = 24;
    localparam int BAND_BYTES = BAND_ROWS / 8;

    localparam logic [7:0] C_ESC       = 8'h1b;
    localparam logic [7:0] C_BIT_IMAGE = 8'h2a;
    localparam logic [7:0] C_MODE_D24  = 8'h21;
    localparam logic [7:0] C_ABS_POS   = 8'h24;
    localparam logic [7:0] C_SPACING   = 8'h33;
    localparam logic [7:0] C_SP_24     = 8'h18;
    localparam logic [7:0] C_SP_DEF    = 8'h32;
    localparam logic [7:0] C_ALIGN     = 8'h61;
    localparam logic [7:0] C_CENTRE    = 8'h01;
    localparam logic [7:0] C_LF        = 8'h0a;

    localparam logic REG_LINE_DOTS   = 1'b0;
    localparam logic REG_WIDTH_BYTES = 1'b1;

    typedef struct packed {
        logic [63:0] rows_top;
        logic [63:0] rows_mid;
        logic [63:0] rows_low;
        logic        prologue;
        logic        header;
        logic        band_end;
        logic        image_end;
        logic [15:0] offset;
        logic [10:0] dots;
    } t_item;

    function automatic logic [7:0] col_byte(input logic [63:0] rows, input logic [2:0] col);
        logic [63:0] shifted;
        logic [7:0]  value;
        shifted = rows << col;
        for (int i = 0; i < 8; i++) begin
            value[7 - i] = shifted[63 - 8 * i];
        end
        return value;
    endfunction

endpackage

`default_nettype wire

>>> hdl/r24c_front.sv
// Front end: accepts column groups, classifies them and tracks band/image state.
// Depends on r24c_pkg for the queue item type.
`default_nettype none

module r24c_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [15:0]     i_line_dots,
    input  wire logic [7:0]      i_width_bytes,
    input  wire logic            i_tvalid,
    input  wire logic [191:0]    i_tdata,
    input  wire logic            i_tuser,
    input  wire logic            i_q_ready,
    output logic                 o_tready,
    output logic                 o_push,
    output r24c_pkg::t_item      o_item
);

    logic [7:0]  r_count;
    logic        r_started;
    logic [10:0] dots;
    logic [16:0] diff;
    logic [8:0]  next_count;
    logic        band_end;

    assign dots       = {i_width_bytes, 3'b000};
    assign diff       = {1'b0, i_line_dots} - {6'b0, dots};
    assign next_count = {1'b0, r_count} + 9'd1;
    assign band_end   = next_count >= {1'b0, i_width_bytes};

    assign o_tready = i_q_ready;
    assign o_push   = i_tvalid && i_q_ready;

    always_comb begin
        o_item.rows_top  = i_tdata[63:0];
        o_item.rows_mid  = i_tdata[127:64];
        o_item.rows_low  = i_tdata[191:128];
        o_item.prologue  = !r_started;
        o_item.header    = (r_count == 8'd0);
        o_item.band_end  = band_end;
        o_item.image_end = band_end && i_tuser;
        o_item.offset    = diff[16] ? 16'd0 : {1'b0, diff[15:1]};
        o_item.dots      = dots;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= 8'd0;
            r_started <= 1'b0;
        end else if (o_push) begin
            r_count   <= band_end ? 8'd0 : next_count[7:0];
            r_started <= !(band_end && i_tuser);
        end
    end

endmodule

`default_nettype wire

>>> hdl/r24c_queue.sv
// Two-entry queue between the front end and the byte sequencer.
// Depends on r24c_pkg for the item type.
`default_nettype none

module r24c_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire r24c_pkg::t_item i_item,
    input  wire logic            i_pop,
    output logic                 o_ready,
    output logic                 o_valid,
    output r24c_pkg::t_item      o_item
);

    r24c_pkg::t_item r_mem [2];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;
    logic            do_push;
    logic            do_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/r24c_back.sv
// Byte sequencer: walks the command bytes of the queue head into an output register.
// Depends on r24c_pkg for the item type, command constants and column transpose.
`default_nettype none

module r24c_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire r24c_pkg::t_item i_item,
    output logic                 o_pop,
    input  wire logic            i_tready,
    output logic                 o_tvalid,
    output logic [7:0]           o_tdata,
    output logic                 o_tlast
);

    typedef enum logic [2:0] {
        S_PRO,
        S_HDR,
        S_COL,
        S_LF,
        S_END
    } t_phase;

    t_phase      r_phase;
    logic [3:0]  r_sub;
    logic [2:0]  r_col;
    logic [1:0]  r_row;
    logic        r_busy;

    t_phase      cur_phase;
    t_phase      n_phase;
    logic [3:0]  cur_sub;
    logic [3:0]  n_sub;
    logic [2:0]  cur_col;
    logic [2:0]  n_col;
    logic [1:0]  cur_row;
    logic [1:0]  n_row;
    logic [7:0]  n_byte;
    logic        n_last;
    logic        advance;
    logic        fire;
    logic [63:0] rows_sel;

    assign advance = !o_tvalid || i_tready;
    assign fire    = advance && i_valid;
    assign o_pop   = fire && n_last;

    always_comb begin
        if (r_busy) begin
            cur_phase = r_phase;
        end else if (i_item.prologue) begin
            cur_phase = S_PRO;
        end else if (i_item.header) begin
            cur_phase = S_HDR;
        end else begin
            cur_phase = S_COL;
        end
        cur_sub = r_busy ? r_sub : 4'd0;
        cur_col = r_busy ? r_col : 3'd0;
        cur_row = r_busy ? r_row : 2'd0;
    end

    always_comb begin
        case (cur_row)
            2'd0:    rows_sel = i_item.rows_top;
            2'd1:    rows_sel = i_item.rows_mid;
            default: rows_sel = i_item.rows_low;
        endcase
    end

    always_comb begin
        n_phase = cur_phase;
        n_sub   = cur_sub + 4'd1;
        n_col   = cur_col;
        n_row   = cur_row;
        n_last  = 1'b0;
        n_byte  = 8'd0;
        case (cur_phase)
            S_PRO: begin
                case (cur_sub)
                    4'd0:    n_byte = r24c_pkg::C_ESC;
                    4'd1:    n_byte = r24c_pkg::C_ALIGN;
                    4'd2:    n_byte = r24c_pkg::C_CENTRE;
                    4'd3:    n_byte = r24c_pkg::C_ESC;
                    4'd4:    n_byte = r24c_pkg::C_SPACING;
                    default: n_byte = r24c_pkg::C_SP_24;
                endcase
                if (cur_sub == 4'd5) begin
                    n_phase = i_item.header ? S_HDR : S_COL;
                    n_sub   = 4'd0;
                end
            end
            S_HDR: begin
                case (cur_sub)
                    4'd0:    n_byte = r24c_pkg::C_ESC;
                    4'd1:    n_byte = r24c_pkg::C_ABS_POS;
                    4'd2:    n_byte = i_item.offset[7:0];
                    4'd3:    n_byte = i_item.offset[15:8];
                    4'd4:    n_byte = r24c_pkg::C_ESC;
                    4'd5:    n_byte = r24c_pkg::C_BIT_IMAGE;
                    4'd6:    n_byte = r24c_pkg::C_MODE_D24;
                    4'd7:    n_byte = i_item.dots[7:0];
                    default: n_byte = {5'b0, i_item.dots[10:8]};
                endcase
                if (cur_sub == 4'd8) begin
                    n_phase = S_COL;
                    n_sub   = 4'd0;
                end
            end
            S_COL: begin
                n_byte = r24c_pkg::col_byte(rows_sel, cur_col);
                n_sub  = 4'd0;
                if (cur_row == 2'(r24c_pkg::BAND_BYTES - 1)) begin
                    n_row = 2'd0;
                    n_col = cur_col + 3'd1;
                    if (cur_col == 3'd7) begin
                        n_phase = S_LF;
                        n_last  = !i_item.band_end;
                    end
                end else begin
                    n_row = cur_row + 2'd1;
                end
            end
            S_LF: begin
                n_byte  = r24c_pkg::C_LF;
                n_last  = !i_item.image_end;
                n_phase = S_END;
                n_sub   = 4'd0;
            end
            S_END: begin
                n_byte = (cur_sub == 4'd0) ? r24c_pkg::C_ESC : r24c_pkg::C_SP_DEF;
                n_last = (cur_sub != 4'd0);
            end
            default: begin
                n_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= S_PRO;
            r_sub    <= 4'd0;
            r_col    <= 3'd0;
            r_row    <= 2'd0;
            r_busy   <= 1'b0;
            o_tvalid <= 1'b0;
        end else if (fire) begin
            o_tvalid <= 1'b1;
            o_tdata  <= n_byte;
            o_tlast  <= n_last;
            r_busy   <= !n_last;
            r_phase  <= n_phase;
            r_sub    <= n_last ? 4'd0 : n_sub;
            r_col    <= n_last ? 3'd0 : n_col;
            r_row    <= n_last ? 2'd0 : n_row;
        end else if (advance) begin
            o_tvalid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> hdl/raster_to_24dot_column_image.sv
// Top level of the 24-dot column bit-image encoder: register port and stream wiring.
// Depends on r24c_pkg, r24c_front, r24c_queue and r24c_back.
//
//   Channel   Direction  Transaction
//   s stream  in         one 8-dot column group of a 24-row band
//   m stream  out        one byte of the printer command stream
//   APB       in/out     writes and reads of the paper width and image width registers
//
// Each column group gives 24 to 42 bytes, sent one byte per cycle from the output
// register while the sink does not stall.
// The next group is accepted while the current one is still being sent; the queue
// holds the group being sent and one more.
// Synchronous active-low reset clears the band and image state and empties the queue.
// A stall on the output holds the byte in the output register; the input side fills the queue.
`default_nettype none

module raster_to_24dot_column_image (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // rows_top [63:0], rows_mid [127:64], rows_low [191:128]
    input  wire logic [191:0] i_s_tdata,
    // final_band [0]
    input  wire logic         i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // out_byte [7:0]
    output logic [7:0]        o_m_tdata,
    output logic              o_m_tlast,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [15:0]     r_line_dots;
    logic [7:0]      r_width_bytes;
    logic            q_ready;
    logic            q_valid;
    logic            push;
    logic            pop;
    r24c_pkg::t_item front_item;
    r24c_pkg::t_item head_item;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_dots   <= 16'd504;
            r_width_bytes <= 8'd63;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                r24c_pkg::REG_LINE_DOTS:   r_line_dots   <= pwdata[15:0];
                r24c_pkg::REG_WIDTH_BYTES: r_width_bytes <= pwdata[7:0];
                default:                   r_width_bytes <= r_width_bytes;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            r24c_pkg::REG_LINE_DOTS:   prdata = {16'd0, r_line_dots};
            r24c_pkg::REG_WIDTH_BYTES: prdata = {24'd0, r_width_bytes};
            default:                   prdata = 32'd0;
        endcase
    end

    r24c_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_line_dots   (r_line_dots),
        .i_width_bytes (r_width_bytes),
        .i_tvalid      (i_s_tvalid),
        .i_tdata       (i_s_tdata),
        .i_tuser       (i_s_tuser),
        .i_q_ready     (q_ready),
        .o_tready      (o_s_tready),
        .o_push        (push),
        .o_item        (front_item)
    );

    r24c_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    r24c_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (head_item),
        .o_pop    (pop),
        .i_tready (i_m_tready),
        .o_tvalid (o_m_tvalid),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

>>> hdl/r24c_checker.sv
// Port-level checks for the 24-dot column bit-image encoder, bound to the top level.
// Depends only on the ports of raster_to_24dot_column_image.
`default_nettype none

module r24c_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_tvalid,
    input wire logic         o_s_tready,
    input wire logic         o_m_tvalid,
    input wire logic         i_m_tready,
    input wire logic [7:0]   o_m_tdata,
    input wire logic         o_m_tlast
);

    // A held output byte keeps its value while the sink stalls.
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("output byte changed under stall");

    // Bytes of one group follow each other without gaps.
    a_no_gap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=> o_m_tvalid)
        else $error("gap inside the bytes of a column group");

    // A group accepted while the output is empty appears once it has passed the queue and the output register.
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !o_m_tvalid) |=> ##1 o_m_tvalid)
        else $error("accepted column group produced no output");

    // The input side is never blocked while the output is idle.
    a_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid && $past(!o_m_tvalid) && $past(i_rst_n)) |-> o_s_tready)
        else $error("input stalled with the output idle");

endmodule

bind raster_to_24dot_column_image r24c_checker u_r24c_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
